// ===== rtl/core/cci_pkg.sv =====
// Shared types and constants for the commodity channel index block.
`default_nettype none

package cci_pkg;

    localparam int PRICE_W = 24;              // one price field
    localparam int TP_W    = 26;              // high + low + close
    localparam int PER_W   = 7;               // period register
    localparam int OUT_W   = 24;              // cci value
    localparam int Q_W     = 24;              // quotient bits
    localparam int Q_CNT_W = $clog2(Q_W);
    localparam int SCALE_W = 16;

    localparam logic [PER_W-1:0]   PERIOD_RESET = 7'd20;
    localparam logic [SCALE_W-1:0] SCALE_K      = 16'd51200;   // 200 * 256
    localparam logic [OUT_W-1:0]   NEG_LIMIT    = 24'h800000;
    localparam logic [OUT_W-1:0]   POS_LIMIT    = 24'h7FFFFF;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_UPDATE,
        OP_DEV_ISSUE,
        OP_MAG,
        OP_SCALE,
        OP_NUM,
        OP_CHK,
        OP_DIV_STEP,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic warm_up;     // bar leaves no result
        logic issue_last;  // last window entry being read
        logic pipe_busy;   // deviation pipeline not empty
        logic div_last;    // last quotient bit this cycle
        logic out_full;    // result word not yet taken
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/cci_bar_if.sv =====
// Bar channel: valid/ready handshake with high, low and close prices.
`default_nettype none

interface cci_bar_if;
    logic                          valid;
    logic                          ready;
    logic [cci_pkg::PRICE_W-1:0]   high_price;
    logic [cci_pkg::PRICE_W-1:0]   low_price;
    logic [cci_pkg::PRICE_W-1:0]   close_price;

    modport source (output valid, output high_price, output low_price,
                    output close_price, input ready);
    modport sink   (input valid, input high_price, input low_price,
                    input close_price, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cci_res_if.sv =====
// Result channel: valid/ready handshake with cci value and zero deviation flag.
`default_nettype none

interface cci_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [cci_pkg::OUT_W-1:0]   cci_value;
    logic                               zero_deviation;

    modport source (output valid, output cci_value, output zero_deviation,
                    input ready);
    modport sink   (input valid, input cci_value, input zero_deviation,
                     output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cci_ctrl.sv =====
// Sequencer that steps each bar through update, deviation sum and division.
`default_nettype none

module cci_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire cci_pkg::t_sts i_sts,
    output cci_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_DEV,
        S_DRAIN,
        S_MAG,
        S_SCALE,
        S_NUM,
        S_CHK,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = cci_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = cci_pkg::OP_CAPTURE;
                    n_state  = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.op = cci_pkg::OP_UPDATE;
                n_state  = i_sts.warm_up ? S_IDLE : S_DEV;
            end
            S_DEV: begin
                o_cmd.op = cci_pkg::OP_DEV_ISSUE;
                if (i_sts.issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_MAG;
                end
            end
            S_MAG: begin
                o_cmd.op = cci_pkg::OP_MAG;
                n_state  = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.op = cci_pkg::OP_SCALE;
                n_state  = S_NUM;
            end
            S_NUM: begin
                o_cmd.op = cci_pkg::OP_NUM;
                n_state  = S_CHK;
            end
            S_CHK: begin
                o_cmd.op = cci_pkg::OP_CHK;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = cci_pkg::OP_DIV_STEP;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_full) begin
                    o_cmd.op = cci_pkg::OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cci_datapath.sv =====
// Window store, running sum, deviation pipeline, scaling and restoring divider.
`default_nettype none

module cci_datapath #(
    parameter int MAX_PERIOD = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cci_pkg::t_cmd                 i_cmd,
    output cci_pkg::t_sts                      o_sts,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [cci_pkg::PER_W-1:0]     i_cfg_wr_data,
    input  wire logic [cci_pkg::PRICE_W-1:0]   i_high_price,
    input  wire logic [cci_pkg::PRICE_W-1:0]   i_low_price,
    input  wire logic [cci_pkg::PRICE_W-1:0]   i_close_price,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output logic signed [cci_pkg::OUT_W-1:0]   o_cci_value,
    output logic                               o_zero_deviation
);

    localparam int PER_W   = cci_pkg::PER_W;
    localparam int TP_W    = cci_pkg::TP_W;
    localparam int OUT_W   = cci_pkg::OUT_W;
    localparam int Q_W     = cci_pkg::Q_W;
    localparam int PER_MAX = (2 ** PER_W) - 1;
    localparam int EFF_MAX = (MAX_PERIOD < PER_MAX) ? MAX_PERIOD : PER_MAX;
    localparam int AW      = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
    localparam int XW      = (AW > PER_W) ? AW : PER_W;
    localparam int XW1     = XW + 1;
    localparam int SEEN_W  = PER_W + 1;
    localparam int LOG_P   = $clog2(EFF_MAX + 1);
    localparam int SUM_W   = TP_W + LOG_P;
    localparam int PT_W    = PER_W + TP_W;
    localparam int DEV_W   = SUM_W + LOG_P;
    localparam int DV3_W   = DEV_W + 2;
    localparam int DEN_W   = DV3_W + 1;
    localparam int PK_W    = PER_W + cci_pkg::SCALE_W;
    localparam int SC_W    = SUM_W + PK_W;
    localparam int NUM_W   = SC_W + 2;
    localparam int CMP_W   = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [TP_W-1:0]   r_mem [MAX_PERIOD];

    logic [PER_W-1:0]  r_period;
    logic [AW-1:0]     r_pos;
    logic [SEEN_W-1:0] r_seen;
    logic [SUM_W-1:0]  r_sum;
    logic [TP_W-1:0]   r_tp;
    logic [TP_W-1:0]   r_rdata;
    logic [AW-1:0]     r_j;
    logic              r_v1, r_v2, r_v3;
    logic [SUM_W-1:0]  r_prod;
    logic [SUM_W-1:0]  r_absd;
    logic [DEV_W-1:0]  r_acc;
    logic [SUM_W-1:0]  r_pt;
    logic [SUM_W-1:0]  r_mag;
    logic              r_neg;
    logic [DV3_W-1:0]  r_dv3;
    logic [PK_W-1:0]   r_pk;
    logic [SC_W-1:0]   r_scaled;
    logic [CMP_W-1:0]  r_rem;
    logic [CMP_W-1:0]  r_den_sh;
    logic [Q_W-1:0]    r_q;
    logic [cci_pkg::Q_CNT_W-1:0] r_bit;
    logic              r_ovf;
    logic              r_res_valid;
    logic [OUT_W-1:0]  r_val;
    logic              r_zero;

    logic [PER_W-1:0]  p_eff;
    logic [SEEN_W-1:0] need;
    logic [AW-1:0]     pos_eff;
    logic [XW1-1:0]    pos_inc;
    logic [AW-1:0]     pos_nxt;
    logic [SEEN_W-1:0] seen_inc;
    logic [TP_W-1:0]   old_tp;
    logic [SUM_W-1:0]  n_sum;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [PT_W-1:0]   pt_full;
    logic [PT_W-1:0]   prod_full;
    logic [DEN_W-1:0]  den;
    logic              ge;
    logic [Q_W-1:0]    qv;
    logic [OUT_W-1:0]  q_lim;
    logic [OUT_W-1:0]  n_val;
    logic              n_zero;

    always_comb begin
        if (r_period == '0) begin
            p_eff = PER_W'(1);
        end else if (r_period > PER_W'(EFF_MAX)) begin
            p_eff = PER_W'(EFF_MAX);
        end else begin
            p_eff = r_period;
        end
    end

    assign need     = {p_eff, 1'b0} - SEEN_W'(1);
    assign pos_eff  = (XW'(r_pos) >= XW'(p_eff)) ? '0 : r_pos;
    assign pos_inc  = XW1'(pos_eff) + XW1'(1);
    assign pos_nxt  = (pos_inc >= XW1'(p_eff)) ? '0 : AW'(pos_inc);
    assign seen_inc = (r_seen < need) ? r_seen + SEEN_W'(1) : r_seen;
    assign old_tp   = (r_seen >= SEEN_W'(p_eff)) ? r_rdata : '0;
    assign n_sum    = r_sum - SUM_W'(old_tp) + SUM_W'(r_tp);

    assign rd_en    = (i_cmd.op == cci_pkg::OP_CAPTURE) ||
                      (i_cmd.op == cci_pkg::OP_DEV_ISSUE);
    assign rd_addr  = (i_cmd.op == cci_pkg::OP_CAPTURE) ? pos_eff : r_j;

    assign pt_full   = PT_W'(p_eff) * PT_W'(r_tp);
    assign prod_full = PT_W'(p_eff) * PT_W'(r_rdata);
    assign den       = {r_dv3, 1'b0};
    assign ge        = (r_rem >= r_den_sh);

    assign o_sts.warm_up    = (seen_inc < need);
    assign o_sts.issue_last = (XW'(r_j) == XW'(p_eff - PER_W'(1)));
    assign o_sts.pipe_busy  = r_v1 | r_v2 | r_v3;
    assign o_sts.div_last   = (r_bit == '0);
    assign o_sts.out_full   = r_res_valid;

    // round-half-up quotient, saturated to the signed output range
    always_comb begin
        qv     = r_ovf ? '1 : r_q;
        q_lim  = '0;
        n_val  = '0;
        n_zero = 1'b0;
        if (r_dv3 == '0) begin
            n_zero = 1'b1;
        end else if (r_neg) begin
            q_lim = (qv > cci_pkg::NEG_LIMIT) ? cci_pkg::NEG_LIMIT : qv;
            n_val = OUT_W'(0) - q_lim;
        end else begin
            q_lim = (qv > cci_pkg::POS_LIMIT) ? cci_pkg::POS_LIMIT : qv;
            n_val = q_lim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == cci_pkg::OP_UPDATE) begin
            r_mem[pos_eff] <= r_tp;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= cci_pkg::PERIOD_RESET;
            r_pos       <= '0;
            r_seen      <= '0;
            r_sum       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_v1 <= (i_cmd.op == cci_pkg::OP_DEV_ISSUE);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
                r_pos    <= '0;
                r_seen   <= '0;
                r_sum    <= '0;
            end else if (i_cmd.op == cci_pkg::OP_UPDATE) begin
                r_pos  <= pos_nxt;
                r_seen <= seen_inc;
                r_sum  <= n_sum;
            end
            if (i_cmd.op == cci_pkg::OP_FINISH) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= SUM_W'(prod_full);
        r_absd <= (r_sum >= r_prod) ? r_sum - r_prod : r_prod - r_sum;
        if (r_v3) begin
            r_acc <= r_acc + DEV_W'(r_absd);
        end
        case (i_cmd.op)
            cci_pkg::OP_CAPTURE: begin
                r_tp <= TP_W'(i_high_price) + TP_W'(i_low_price) + TP_W'(i_close_price);
            end
            cci_pkg::OP_UPDATE: begin
                r_pt  <= SUM_W'(pt_full);
                r_j   <= '0;
                r_acc <= '0;
            end
            cci_pkg::OP_DEV_ISSUE: begin
                r_j <= r_j + AW'(1);
            end
            cci_pkg::OP_MAG: begin
                r_neg <= (r_pt < r_sum);
                r_mag <= (r_pt < r_sum) ? r_sum - r_pt : r_pt - r_sum;
                r_dv3 <= DV3_W'({r_acc, 1'b0}) + DV3_W'(r_acc);
                r_pk  <= PK_W'(p_eff) * PK_W'(cci_pkg::SCALE_K);
            end
            cci_pkg::OP_SCALE: begin
                r_scaled <= SC_W'(r_mag) * SC_W'(r_pk);
            end
            cci_pkg::OP_NUM: begin
                r_rem    <= CMP_W'(NUM_W'({r_scaled, 1'b0}) + NUM_W'(r_dv3));
                r_den_sh <= CMP_W'(den) << (Q_W - 1);
                r_q      <= '0;
                r_bit    <= cci_pkg::Q_CNT_W'(Q_W - 1);
            end
            cci_pkg::OP_CHK: begin
                r_ovf <= (r_rem >= (CMP_W'(den) << Q_W));
            end
            cci_pkg::OP_DIV_STEP: begin
                if (ge) begin
                    r_rem <= r_rem - r_den_sh;
                end
                r_q      <= {r_q[Q_W-2:0], ge};
                r_den_sh <= r_den_sh >> 1;
                r_bit    <= r_bit - cci_pkg::Q_CNT_W'(1);
            end
            cci_pkg::OP_FINISH: begin
                r_val  <= n_val;
                r_zero <= n_zero;
            end
            default: begin
            end
        endcase
    end

    assign o_res_valid      = r_res_valid;
    assign o_cci_value      = $signed(r_val);
    assign o_zero_deviation = r_zero;

endmodule

`default_nettype wire

// ===== rtl/core/commodity_channel_index_unit.sv =====
// Top level of the commodity channel index block.
//
//  channel   dir  handshake      word
//  i_bar     in   valid/ready    high_price, low_price, close_price (24b unsigned)
//  o_res     out  valid/ready    cci_value (24b signed, 8 frac), zero_deviation
//  cfg       in   i_cfg_wr_en    i_cfg_wr_data = period_length (7b)
//
//  Warm-up bars pass through capture and update only; result bars read one window
//  entry per cycle through the single store read port, drain a 3-stage deviation
//  pipeline, then run 4 scale/check steps, a 24-step restoring divider and a
//  finish step that waits while the previous word is not yet taken.
//  Reset and period writes clear the ring position, bar count and running sum.
//  A finished word waits in the output register; the next bar is taken meanwhile.
`default_nettype none

module commodity_channel_index_unit #(
    parameter int MAX_PERIOD = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    cci_bar_if.sink                        i_bar,
    cci_res_if.source                      o_res,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [cci_pkg::PER_W-1:0] i_cfg_wr_data
);

    cci_pkg::t_cmd cmd;
    cci_pkg::t_sts sts;
    logic          in_ready;

    assign i_bar.ready = in_ready;

    cci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_bar.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cci_datapath #(
        .MAX_PERIOD (MAX_PERIOD)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_high_price     (i_bar.high_price),
        .i_low_price      (i_bar.low_price),
        .i_close_price    (i_bar.close_price),
        .o_res_valid      (o_res.valid),
        .i_res_ready      (o_res.ready),
        .o_cci_value      (o_res.cci_value),
        .o_zero_deviation (o_res.zero_deviation)
    );

endmodule

`default_nettype wire

// ===== tb/tb_commodity_channel_index_unit.sv =====
// Self-checking testbench for the CCI block: random bars and stalls, predicted words.
`timescale 1ns / 100ps

module tb_commodity_channel_index_unit;

    localparam int          WIN_MAX    = 64;
    localparam int          SETTLE_CYC = 120;
    localparam int          IDLE_LIMIT = 3000;
    localparam logic [23:0] PRICE_MAX  = 24'hFFFFFF;

    typedef struct packed {
        logic [cci_pkg::PRICE_W-1:0] high_price;
        logic [cci_pkg::PRICE_W-1:0] low_price;
        logic [cci_pkg::PRICE_W-1:0] close_price;
    } t_bar;

    typedef struct packed {
        logic signed [cci_pkg::OUT_W-1:0] cci_value;
        logic                             zero_deviation;
    } t_cci_word;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [cci_pkg::PER_W-1:0] i_cfg_wr_data;

    cci_bar_if bar_ch ();
    cci_res_if res_ch ();

    commodity_channel_index_unit #(.MAX_PERIOD(WIN_MAX)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bar         (bar_ch),
        .o_res         (res_ch),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // predictor state
    logic [cci_pkg::PER_W-1:0] period_reg;
    logic [cci_pkg::TP_W-1:0]  win_tp [WIN_MAX];
    int unsigned               win_pos;
    int unsigned               win_count;
    logic [63:0]               win_sum;

    t_bar        bar_pending_q [$];
    t_cci_word   cci_expected_q [$];
    t_bar        drv_bar;
    t_cci_word   got_word;
    int unsigned drv_gap;
    int unsigned mon_stall;
    int unsigned idle_cyc;
    int unsigned err_count;
    bit          calm;

    always #5 i_clk = ~i_clk;

    function automatic int unsigned eff_len();
        if (period_reg == 0) begin
            return 1;
        end
        if (period_reg > WIN_MAX) begin
            return WIN_MAX;
        end
        return period_reg;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(16, 80);
    endfunction

    function automatic logic [23:0] near(logic [23:0] base, int spread);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) begin
            v = 0;
        end
        if (v > int'(PRICE_MAX)) begin
            v = int'(PRICE_MAX);
        end
        return 24'(v);
    endfunction

    function automatic t_bar random_bar(logic [23:0] base);
        int unsigned r;
        t_bar b;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            b.high_price  = near(base, 4096);
            b.low_price   = near(base, 4096);
            b.close_price = near(base, 4096);
        end else if (r < 75) begin
            b.high_price  = 24'($urandom);
            b.low_price   = 24'($urandom);
            b.close_price = 24'($urandom);
        end else if (r < 85) begin
            b.high_price  = $urandom_range(0, 1) ? PRICE_MAX : 24'd0;
            b.low_price   = $urandom_range(0, 1) ? PRICE_MAX : 24'd0;
            b.close_price = $urandom_range(0, 1) ? PRICE_MAX : 24'd0;
        end else begin
            b.high_price  = 24'($urandom_range(0, 15));
            b.low_price   = 24'($urandom_range(0, 15));
            b.close_price = 24'($urandom_range(0, 15));
        end
        return b;
    endfunction

    // ring update and CCI prediction for one accepted bar
    task automatic absorb_bar(input t_bar b);
        int unsigned p;
        int unsigned pos;
        int unsigned need;
        logic [cci_pkg::TP_W-1:0] tp;
        logic [63:0] pv;
        logic [63:0] dev;
        logic [63:0] mag;
        logic [63:0] q;
        logic        neg;
        t_cci_word   w;
        p    = eff_len();
        need = 2 * p - 1;
        pos  = (win_pos >= p) ? 0 : win_pos;
        tp   = cci_pkg::TP_W'(b.high_price) + cci_pkg::TP_W'(b.low_price)
             + cci_pkg::TP_W'(b.close_price);
        if (win_count >= p) begin
            win_sum = win_sum - 64'(win_tp[pos]);
        end
        win_tp[pos] = tp;
        win_sum     = win_sum + 64'(tp);
        win_pos     = (pos + 1 >= p) ? 0 : pos + 1;
        if (win_count < need) begin
            win_count++;
        end
        if (win_count >= need) begin
            dev = 0;
            for (int j = 0; j < p; j++) begin
                pv  = 64'(p) * 64'(win_tp[j]);
                dev = dev + ((win_sum >= pv) ? win_sum - pv : pv - win_sum);
            end
            if (dev == 0) begin
                w.cci_value      = '0;
                w.zero_deviation = 1'b1;
            end else begin
                pv  = 64'(p) * 64'(tp);
                neg = pv < win_sum;
                mag = neg ? win_sum - pv : pv - win_sum;
                mag = mag * 64'(p) * 64'(cci_pkg::SCALE_K);
                dev = dev * 3;
                q   = (2 * mag + dev) / (2 * dev);
                if (neg) begin
                    if (q > 64'(cci_pkg::NEG_LIMIT)) begin
                        q = 64'(cci_pkg::NEG_LIMIT);
                    end
                    w.cci_value = cci_pkg::OUT_W'(64'd0 - q);
                end else begin
                    if (q > 64'(cci_pkg::POS_LIMIT)) begin
                        q = 64'(cci_pkg::POS_LIMIT);
                    end
                    w.cci_value = cci_pkg::OUT_W'(q);
                end
                w.zero_deviation = 1'b0;
            end
            cci_expected_q.push_back(w);
        end
    endtask

    task automatic report_mismatch(input string what);
        if (err_count < 50) begin
            $display("%0t mismatch: %s", $time, what);
        end
        err_count++;
    endtask

    task automatic queue_bar(input logic [23:0] h, input logic [23:0] l, input logic [23:0] c);
        bar_pending_q.push_back({h, l, c});
    endtask

    // sampled mid-cycle so that the driver's updates at the edge have settled
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (bar_pending_q.size() != 0 || bar_ch.valid || cci_expected_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_period(input logic [cci_pkg::PER_W-1:0] v);
        wait_idle();
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        period_reg = v;
        win_pos    = 0;
        win_count  = 0;
        win_sum    = 0;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        calm = ($urandom_range(0, 3) == 0);
    endtask

    // content mostly near a base that jumps at random, with constant runs
    task automatic fill_random(input int n);
        int i;
        int unsigned r;
        logic [23:0] base;
        t_bar b;
        i    = 0;
        base = 24'($urandom);
        while (i < n) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                b = random_bar(base);
                repeat (eff_len() + 2) bar_pending_q.push_back(b);
                i += eff_len() + 2;
            end else if (r < 8) begin
                base = 24'($urandom);
            end else begin
                bar_pending_q.push_back(random_bar(base));
                i++;
            end
        end
    endtask

    // bar driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bar_ch.valid <= 1'b0;
            drv_gap      <= 0;
        end else begin
            if (bar_ch.valid && bar_ch.ready) begin
                absorb_bar({bar_ch.high_price, bar_ch.low_price, bar_ch.close_price});
            end
            if (!bar_ch.valid || bar_ch.ready) begin
                if (drv_gap != 0) begin
                    bar_ch.valid <= 1'b0;
                    drv_gap      <= drv_gap - 1;
                end else if (bar_pending_q.size() != 0) begin
                    drv_bar = bar_pending_q.pop_front();
                    bar_ch.high_price  <= drv_bar.high_price;
                    bar_ch.low_price   <= drv_bar.low_price;
                    bar_ch.close_price <= drv_bar.close_price;
                    bar_ch.valid       <= 1'b1;
                    drv_gap            <= gap_len();
                end else begin
                    bar_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            mon_stall    <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (cci_expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word cci=%0d zero_dev=%0b",
                                    res_ch.cci_value, res_ch.zero_deviation));
                end else begin
                    got_word = cci_expected_q.pop_front();
                    if (res_ch.cci_value !== got_word.cci_value) begin
                        report_mismatch($sformatf("cci_value got %0d exp %0d",
                                        res_ch.cci_value, got_word.cci_value));
                    end
                    if (res_ch.zero_deviation !== got_word.zero_deviation) begin
                        report_mismatch($sformatf("zero_deviation got %0b exp %0b",
                                        res_ch.zero_deviation, got_word.zero_deviation));
                    end
                end
            end
            if (mon_stall != 0) begin
                res_ch.ready <= 1'b0;
                mon_stall    <= mon_stall - 1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                res_ch.ready <= 1'b0;
                mon_stall    <= gap_len();
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (bar_ch.valid && bar_ch.ready) || (res_ch.valid && res_ch.ready)
                || i_cfg_wr_en) begin
            idle_cyc <= 0;
        end else if (idle_cyc >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_wr_data      = '0;
        bar_ch.valid       = 1'b0;
        bar_ch.high_price  = '0;
        bar_ch.low_price   = '0;
        bar_ch.close_price = '0;
        res_ch.ready       = 1'b0;
        period_reg         = cci_pkg::PERIOD_RESET;
        win_pos            = 0;
        win_count          = 0;
        win_sum            = 0;
        err_count          = 0;
        idle_cyc           = 0;
        calm               = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset period, no write yet
        fill_random(200);

        // short windows (3, 1, 0): zero deviation, extremes, bit patterns
        set_period(7'd3);
        repeat (5) queue_bar(24'd0, 24'd0, 24'd0);
        repeat (5) queue_bar(PRICE_MAX, PRICE_MAX, PRICE_MAX);
        queue_bar(24'd0, 24'd0, 24'd0);
        queue_bar(PRICE_MAX, PRICE_MAX, PRICE_MAX);
        queue_bar(24'd0, 24'd0, 24'd0);
        queue_bar(PRICE_MAX, 24'd0, 24'd0);
        queue_bar(24'd0, PRICE_MAX, 24'd0);
        queue_bar(24'd0, 24'd0, PRICE_MAX);
        queue_bar(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
        queue_bar(24'h555555, 24'hAAAAAA, 24'h555555);
        set_period(7'd1);
        queue_bar(PRICE_MAX, 24'd0, PRICE_MAX);
        queue_bar(24'd1, 24'd2, 24'd3);
        set_period(7'd0);
        queue_bar(PRICE_MAX, PRICE_MAX, 24'd0);
        queue_bar(24'd0, 24'd0, 24'd1);

        set_period(7'd64);
        fill_random(300);
        set_period(7'd127);
        fill_random(200);
        set_period(7'd65);
        fill_random(200);
        set_period(7'd2);
        fill_random(150);
        set_period(7'd1);
        fill_random(100);
        set_period(7'd0);
        fill_random(100);
        set_period(7'd5);
        fill_random(200);
        set_period(7'd33);
        fill_random(250);
        set_period(7'($urandom_range(1, 64)));
        fill_random(250);

        wait_idle();
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
